[rtl/core/md5_message_digest_defines.svh]
// Assertion macros shared by the MD5 digest RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef MD5_MESSAGE_DIGEST_DEFINES_SVH
`define MD5_MESSAGE_DIGEST_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MD5_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("MD5 assertion failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MD5_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("MD5 assertion failed one cycle later");

`endif

[rtl/core/md5_pkg.sv]
// Shared types, constants and helper functions of the MD5 digest block.
// No dependencies; used by md5_round and the top level.
package md5_pkg;

   // Four 32-bit words of chaining or working state, index 0 is word A.
   typedef logic [3:0][31:0] chain_type;

   // Control from the sequencer to the round datapath.
   typedef struct packed {
      logic init;   // load working words from the chaining words
      logic prime;  // form the first round's pre-sum
      logic step;   // perform one round
   } round_ctrl_type;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hEFCDAB89;
   localparam logic [31:0] IV_C = 32'h98BADCFE;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   localparam int unsigned WORD_DEPTH = 16;

   // Additive round constants.
   localparam logic [31:0] ROUND_K [64] = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
      32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
      32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
      32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
      32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
      32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
      32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
      32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
      32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
   };

   // Rotation amounts, indexed by round group and round modulo four.
   localparam logic [4:0] ROT_AMOUNT [16] = '{
      5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
      5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
   };

   // Message word used by a given round.
   function automatic logic [3:0] word_sel(input logic [5:0] rnd);
      logic [3:0] n;
      logic [3:0] g;
      n = rnd[3:0];
      case (rnd[5:4])
         2'd0:    g = n;
         2'd1:    g = n * 4'd5 + 4'd1;
         2'd2:    g = n * 4'd3 + 4'd5;
         default: g = n * 4'd7;
      endcase
      return g;
   endfunction

   // Rotate left by a non-zero amount.
   function automatic logic [31:0] rotl(input logic [31:0] v, input logic [4:0] n);
      logic [63:0] wide;
      wide = {v, v} << n;
      return wide[63:32];
   endfunction

endpackage

[rtl/core/md5_if.sv]
// Handshake channel interfaces of the MD5 digest block.
// Depends on nothing; the top level uses one of each.
interface md5_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink   (input valid, input action, input data_byte, output ready);
endinterface

interface md5_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [1:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last_word,
                   output ready);
endinterface

[rtl/core/md5_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module md5_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/md5_round.sv]
// MD5 round datapath: working words, round counter and the one-round-per-cycle step.
// Depends on md5_pkg; takes message words from the block RAM in the cycle after addressing.
module md5_round (
   input  logic                  clock,
   input  logic                  reset,
   input  md5_pkg::round_ctrl_type ctrl,
   input  md5_pkg::chain_type    chain,
   input  logic [31:0]           w_word,
   output md5_pkg::chain_type    work,
   output logic [3:0]            rd_addr,
   output logic                  round_last
);

   md5_pkg::chain_type work_ff, work_in;
   logic [31:0] pre_ff, pre_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [5:0]  rnd_next, rnd_next2;
   logic [31:0] f_val, sum_val, rot_val;
   logic [4:0]  shift;

   assign rnd_next  = rnd_ff + 6'd1;
   assign rnd_next2 = rnd_ff + 6'd2;

   // Round function of the current group.
   always_comb begin
      case (rnd_ff[5:4])
         2'd0:    f_val = (work_ff[1] & work_ff[2]) | (~work_ff[1] & work_ff[3]);
         2'd1:    f_val = (work_ff[3] & work_ff[1]) | (~work_ff[3] & work_ff[2]);
         2'd2:    f_val = work_ff[1] ^ work_ff[2] ^ work_ff[3];
         default: f_val = work_ff[2] ^ (work_ff[1] | ~work_ff[3]);
      endcase
   end

   // The pre-sum already holds A + K + W, so a round adds F, rotates and adds B.
   assign shift   = md5_pkg::ROT_AMOUNT[{rnd_ff[5:4], rnd_ff[1:0]}];
   assign sum_val = pre_ff + f_val;
   assign rot_val = md5_pkg::rotl(sum_val, shift);

   // Next-state logic; the RAM is addressed one round ahead of the pre-sum.
   always_comb begin
      work_in = work_ff;
      pre_in  = pre_ff;
      rnd_in  = rnd_ff;
      rd_addr = 4'd0;
      if (ctrl.init) begin
         work_in = chain;
         rd_addr = md5_pkg::word_sel(6'd0);
      end
      if (ctrl.prime) begin
         pre_in  = chain[0] + md5_pkg::ROUND_K[0] + w_word;
         rnd_in  = 6'd0;
         rd_addr = md5_pkg::word_sel(6'd1);
      end
      if (ctrl.step) begin
         work_in[0] = work_ff[3];
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[1] + rot_val;
         // The next round's A is the current D.
         pre_in  = work_ff[3] + md5_pkg::ROUND_K[rnd_next] + w_word;
         rnd_in  = rnd_next;
         rd_addr = md5_pkg::word_sel(rnd_next2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_ff <= 6'd0;
      end else begin
         rnd_ff <= rnd_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      pre_ff  <= pre_in;
   end

   assign work       = work_ff;
   assign round_last = (rnd_ff == 6'd63);

endmodule

[rtl/core/md5_message_digest.sv]
// MD5 digest top level: byte intake, padding sequencer, chaining words and digest output.
// Bytes are absorbed only while idle; each full 64-byte block then runs a compression
// (load, prime, 64 rounds at one per cycle, fold) before the next byte is taken.
// A finish item pads one byte per cycle up to the block end, compresses once or twice,
// then offers one digest word per cycle through the output register unless ready is held low.
// Reset is synchronous: chaining words return to the initial values, counts clear.
`include "md5_message_digest_defines.svh"

module md5_message_digest (
   input  logic      clock,
   input  logic      reset,
   md5_req_if.sink   req_chan,
   md5_rsp_if.source rsp_chan
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PAD   = 3'd1;
   localparam logic [2:0] S_LEN   = 3'd2;
   localparam logic [2:0] S_LOAD  = 3'd3;
   localparam logic [2:0] S_PRIME = 3'd4;
   localparam logic [2:0] S_ROUND = 3'd5;
   localparam logic [2:0] S_FOLD  = 3'd6;
   localparam logic [2:0] S_EMIT  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  ret_ff, ret_in;
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic        pad_first_ff, pad_first_in;
   logic [23:0] acc_ff, acc_in;
   logic [1:0]  idx_ff, idx_in;
   md5_pkg::chain_type chain_ff, chain_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_word_ff, rsp_word_in;
   logic [1:0]  rsp_index_ff, rsp_index_in;
   logic        rsp_last_ff, rsp_last_in;

   logic        req_take;
   logic        push;
   logic [7:0]  push_byte;
   logic        wr_en;
   logic [31:0] wr_data;
   logic [3:0]  rd_addr;
   logic [31:0] rd_data;
   logic        emit_load;
   logic        round_last;
   md5_pkg::round_ctrl_type round_ctrl;
   md5_pkg::chain_type work;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign emit_load      = (state_ff == S_EMIT) && (!rsp_valid_ff || rsp_chan.ready);

   // Byte source: message bytes when idle, pad and length bytes while finishing.
   always_comb begin
      push      = 1'b0;
      push_byte = 8'd0;
      case (state_ff)
         S_IDLE: begin
            push      = req_take && !req_chan.action;
            push_byte = req_chan.data_byte;
         end
         S_PAD: begin
            push      = 1'b1;
            push_byte = pad_first_ff ? md5_pkg::PAD_BYTE : 8'd0;
         end
         S_LEN: begin
            push      = 1'b1;
            push_byte = bits_ff[{fill_ff[2:0], 3'b000} +: 8];
         end
         default: begin
            push      = 1'b0;
            push_byte = 8'd0;
         end
      endcase
   end

   // Bytes gather little-endian into a word; the fourth byte writes the word out.
   assign wr_en   = push && (fill_ff[1:0] == 2'd3);
   assign wr_data = {push_byte, acc_ff};

   always_comb begin
      acc_in = acc_ff;
      if (push && (fill_ff[1:0] != 2'd3)) begin
         acc_in[{fill_ff[1:0], 3'b000} +: 8] = push_byte;
      end
   end

   assign round_ctrl.init  = (state_ff == S_LOAD);
   assign round_ctrl.prime = (state_ff == S_PRIME);
   assign round_ctrl.step  = (state_ff == S_ROUND);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      fill_in      = fill_ff;
      bits_in      = bits_ff;
      pad_first_in = pad_first_ff;
      idx_in       = idx_ff;
      chain_in     = chain_ff;
      if (push) begin
         fill_in = fill_ff + 6'd1;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_take && req_chan.action) begin
               pad_first_in = 1'b1;
               state_in     = S_PAD;
            end else if (req_take) begin
               bits_in = bits_ff + 64'd8;
               if (fill_ff == 6'd63) begin
                  ret_in   = S_IDLE;
                  state_in = S_LOAD;
               end
            end
         end
         S_PAD: begin
            pad_first_in = 1'b0;
            if (fill_ff == 6'd63) begin
               ret_in   = S_PAD;
               state_in = S_LOAD;
            end else if (fill_in == md5_pkg::LEN_POS) begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            if (fill_ff == 6'd63) begin
               ret_in   = S_EMIT;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_PRIME;
         end
         S_PRIME: begin
            state_in = S_ROUND;
         end
         S_ROUND: begin
            if (round_last) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            chain_in[0] = chain_ff[0] + work[0];
            chain_in[1] = chain_ff[1] + work[1];
            chain_in[2] = chain_ff[2] + work[2];
            chain_in[3] = chain_ff[3] + work[3];
            state_in    = ret_ff;
         end
         S_EMIT: begin
            if (emit_load) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  // Digest is out: start the next message afresh.
                  chain_in = {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
                  bits_in  = 64'd0;
                  fill_in  = 6'd0;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register for digest words.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_index_in = rsp_index_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = chain_ff[idx_ff];
         rsp_index_in = idx_ff;
         rsp_last_in  = (idx_ff == 2'd3);
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         fill_ff      <= 6'd0;
         bits_ff      <= 64'd0;
         pad_first_ff <= 1'b0;
         idx_ff       <= 2'd0;
         chain_ff     <= {md5_pkg::IV_D, md5_pkg::IV_C, md5_pkg::IV_B, md5_pkg::IV_A};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         bits_ff      <= bits_in;
         pad_first_ff <= pad_first_in;
         idx_ff       <= idx_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_index_ff <= rsp_index_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.digest_word = rsp_word_ff;
   assign rsp_chan.word_index  = rsp_index_ff;
   assign rsp_chan.last_word   = rsp_last_ff;

   // Message block store, one 32-bit word per entry.
   md5_ram #(
      .WIDTH (32),
      .DEPTH (md5_pkg::WORD_DEPTH)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[5:2]),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   md5_round u_round (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (round_ctrl),
      .chain      (chain_ff),
      .w_word     (rd_data),
      .work       (work),
      .rd_addr    (rd_addr),
      .round_last (round_last)
   );

   // Length bytes are only sent in the last eight byte slots of a block.
   `MD5_ASSERT_SAME(a_len_slot, clock, reset, state_ff == S_LEN, fill_ff[5:3] == 3'b111)
   // The sixty-fourth round is always followed by the fold.
   `MD5_ASSERT_NEXT(a_round_fold, clock, reset, (state_ff == S_ROUND) && round_last,
                    state_ff == S_FOLD)
   // A digest word only appears after the sequencer has loaded it.
   `MD5_ASSERT_SAME(a_rsp_source, clock, reset, $rose(rsp_valid_ff), $past(emit_load))
   // After the last word the length and fill start again from zero.
   `MD5_ASSERT_NEXT(a_restart, clock, reset, emit_load && (idx_ff == 2'd3),
                    (bits_ff == 64'd0) && (fill_ff == 6'd0) && (state_ff == S_IDLE))

endmodule

[sim/testbench.sv]
// Self-checking testbench for md5_message_digest: directed table, then random messages.
// Depends on the md5_req_if and md5_rsp_if interfaces and the top level RTL.
// Digests are predicted by an independent MD5 model kept inside this file.
module testbench;

   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hEFCDAB89;
   localparam logic [31:0] INIT_C = 32'h98BADCFE;
   localparam logic [31:0] INIT_D = 32'h10325476;
   localparam logic [7:0]  PAD_VALUE = 8'h80;
   localparam logic [5:0]  LENGTH_SLOT = 6'd56;

   localparam int unsigned STALL_LIMIT  = 3000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned HOLD_AT_WORD = 4;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned REPORT_LIMIT = 10;
   localparam int unsigned RANDOM_ITEMS = 87;

   // Well-known digests, packed as {word 3, word 2, word 1, word 0}.
   localparam logic [127:0] EMPTY_DIGEST =
      {32'h7E42F8EC, 32'h980980E9, 32'h04B2008F, 32'hD98C1DD4};
   localparam logic [127:0] ABC_DIGEST =
      {32'h727FE128, 32'h7D3F96D6, 32'hB04FD23C, 32'h98500190};

   localparam logic [31:0] SINE_K [64] = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
      32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
      32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
      32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
      32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
      32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
      32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
      32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
      32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
   };

   localparam int ROTATE_BY [16] = '{
      7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
   };

   typedef struct packed {
      logic [31:0] digest_word;
      logic [1:0]  word_index;
      logic        last_word;
   } digest_word_type;

   typedef struct packed {
      logic         action;
      logic [7:0]   data_byte;
      logic         known;
      logic [127:0] digest;
   } stimulus_row_type;

   // Directed rows; a digest is typed in only where it is a textbook value.
   localparam int unsigned DIRECTED_ROWS = 13;
   localparam stimulus_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{ACT_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},
      '{ACT_FINISH, 8'hFF, 1'b1, EMPTY_DIGEST},
      '{ACT_ABSORB, 8'h61, 1'b0, 128'd0},
      '{ACT_ABSORB, 8'h62, 1'b0, 128'd0},
      '{ACT_ABSORB, 8'h63, 1'b0, 128'd0},
      '{ACT_FINISH, 8'hAA, 1'b1, ABC_DIGEST},
      '{ACT_ABSORB, 8'h00, 1'b0, 128'd0},
      '{ACT_ABSORB, 8'hFF, 1'b0, 128'd0},
      '{ACT_FINISH, 8'h55, 1'b0, 128'd0},
      '{ACT_ABSORB, 8'h80, 1'b0, 128'd0},
      '{ACT_FINISH, 8'h00, 1'b0, 128'd0},
      '{ACT_FINISH, 8'h7F, 1'b1, EMPTY_DIGEST},
      '{ACT_ABSORB, 8'h01, 1'b0, 128'd0}
   };

   logic clock = 1'b0;
   logic reset;

   md5_req_if req_bus ();
   md5_rsp_if rsp_bus ();

   md5_message_digest dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always #10 clock = ~clock;

   // Predicted state of the digest engine.
   logic [31:0] chain_words [4];
   logic [63:0] bit_count;
   logic [5:0]  fill_count;
   logic [7:0]  block_bytes [64];

   digest_word_type digest_words_due [$];
   int unsigned     error_count;
   int unsigned     words_checked;

   function automatic void digest_restart();
      chain_words[0] = INIT_A;
      chain_words[1] = INIT_B;
      chain_words[2] = INIT_C;
      chain_words[3] = INIT_D;
      bit_count = 64'd0;
      fill_count = 6'd0;
   endfunction

   // One 64-round compression of the buffered block into the chaining words.
   function automatic void digest_compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, f, t, sum;
      int g, rot;
      for (int i = 0; i < 16; i++) begin
         w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
      end
      a = chain_words[0];
      b = chain_words[1];
      c = chain_words[2];
      d = chain_words[3];
      for (int i = 0; i < 64; i++) begin
         case (i / 16)
            0: begin
               f = (b & c) | (~b & d);
               g = i;
            end
            1: begin
               f = (d & b) | (~d & c);
               g = (5 * i + 1) % 16;
            end
            2: begin
               f = b ^ c ^ d;
               g = (3 * i + 5) % 16;
            end
            default: begin
               f = c ^ (b | ~d);
               g = (7 * i) % 16;
            end
         endcase
         rot = ROTATE_BY[(i / 16) * 4 + (i % 4)];
         sum = a + f + SINE_K[i] + w[g];
         t = d;
         d = c;
         c = b;
         b = b + ((sum << rot) | (sum >> (32 - rot)));
         a = t;
      end
      chain_words[0] += a;
      chain_words[1] += b;
      chain_words[2] += c;
      chain_words[3] += d;
   endfunction

   function automatic void digest_absorb_byte(logic [7:0] value);
      block_bytes[fill_count] = value;
      fill_count = fill_count + 6'd1;
      if (fill_count == 6'd0) begin
         digest_compress_block();
      end
   endfunction

   // Applies one accepted item; returns the digest on a finish, else zero.
   function automatic logic [127:0] digest_apply_item(logic action, logic [7:0] value);
      logic [63:0]  length_bits;
      logic [127:0] digest;
      digest = '0;
      if (action == ACT_ABSORB) begin
         bit_count = bit_count + 64'd8;
         digest_absorb_byte(value);
      end else begin
         length_bits = bit_count;
         digest_absorb_byte(PAD_VALUE);
         while (fill_count != LENGTH_SLOT) begin
            digest_absorb_byte(8'h00);
         end
         for (int i = 0; i < 8; i++) begin
            digest_absorb_byte(length_bits[8*i +: 8]);
         end
         digest = {chain_words[3], chain_words[2], chain_words[1], chain_words[0]};
         digest_restart();
      end
      return digest;
   endfunction

   // Offers one item after a gap and updates the prediction once it is taken.
   task automatic send_item(logic action, logic [7:0] value, int unsigned gap,
                            logic known, logic [127:0] known_digest);
      logic [127:0] digest;
      digest_word_type word;
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.action    <= action;
      req_bus.data_byte <= value;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      digest = digest_apply_item(action, value);
      if (action == ACT_FINISH) begin
         if (known) begin
            digest = known_digest;
         end
         for (int i = 0; i < 4; i++) begin
            word.digest_word = digest[32*i +: 32];
            word.word_index  = 2'(i);
            word.last_word   = (i == 3);
            digest_words_due.push_back(word);
         end
      end
   endtask

   // Result side: random stalls, one long hold, and the comparison itself.
   initial begin : result_side
      digest_word_type got, want;
      int unsigned stall;
      logic calm;
      calm = 1'b0;
      rsp_bus.ready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 9);
         if (words_checked == HOLD_AT_WORD) begin
            stall = HOLD_CYCLES;
         end
         @(negedge clock);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.digest_word = rsp_bus.digest_word;
         got.word_index  = rsp_bus.word_index;
         got.last_word   = rsp_bus.last_word;
         words_checked++;
         if (digest_words_due.size() == 0) begin
            if (error_count < REPORT_LIMIT) begin
               $display("unexpected digest word %h index %0d last %b",
                        got.digest_word, got.word_index, got.last_word);
            end
            error_count++;
         end else begin
            want = digest_words_due.pop_front();
            if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
                got.last_word !== want.last_word) begin
               if (error_count < REPORT_LIMIT) begin
                  $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                           want.digest_word, want.word_index, want.last_word,
                           got.digest_word, got.word_index, got.last_word);
               end
               error_count++;
            end
         end
         // Switch between stalling and free-running stretches now and then.
         if (got.last_word === 1'b1 && $urandom_range(0, 2) == 0) begin
            calm = ~calm;
         end
      end
   end

   // Ends the run if nothing moves on either channel for too long.
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Some tests failed");
      $finish;
   end

   // Stimulus: reset, the directed table, then random messages.
   initial begin : stimulus
      int unsigned random_items;
      int unsigned message_count;
      int unsigned length;
      int unsigned gap_top;
      int unsigned pick;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.action = ACT_ABSORB;
      req_bus.data_byte = 8'h00;
      error_count = 0;
      words_checked = 0;
      random_items = 0;
      message_count = 0;
      digest_restart();
      for (int i = 0; i < 64; i++) begin
         block_bytes[i] = 8'h00;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         send_item(DIRECTED[r].action, DIRECTED[r].data_byte, $urandom_range(0, 9),
                   DIRECTED[r].known, DIRECTED[r].digest);
      end
      // Withdraw the last item before waiting, so that it is not taken twice.
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (digest_words_due.size() != 0) @(posedge clock);

      // Random messages, with lengths clustered around the padding boundaries.
      while (random_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 11);
         case (pick)
            0: length = $urandom_range(0, 3);
            1: length = 55;
            2: length = 56;
            3: length = 63;
            4: length = 64;
            5: length = 65;
            6: length = $urandom_range(119, 129);
            default: length = $urandom_range(0, 60);
         endcase
         // Keep the whole run near its intended number of items.
         if (length > RANDOM_ITEMS - random_items) begin
            length = RANDOM_ITEMS - random_items;
         end
         gap_top = ($urandom_range(0, 3) == 0) ? 0 : 9;
         for (int n = 0; n < length; n++) begin
            send_item(ACT_ABSORB, 8'($urandom_range(0, 255)), $urandom_range(0, gap_top),
                      1'b0, 128'd0);
            random_items++;
         end
         send_item(ACT_FINISH, 8'($urandom_range(0, 255)), $urandom_range(0, gap_top),
                   1'b0, 128'd0);
         random_items++;
         message_count++;
         // Once in the run, hold back until every digest word has come out.
         if (message_count == 1) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            while (digest_words_due.size() != 0) @(posedge clock);
         end
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (digest_words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && digest_words_due.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[md5_message_digest.f]
+incdir+rtl/core
rtl/core/md5_pkg.sv
rtl/core/md5_if.sv
rtl/core/md5_ram.sv
rtl/core/md5_round.sv
rtl/core/md5_message_digest.sv
sim/testbench.sv
